### src/emet_pkg.sv
// shared types and constants for the exact match exclusion table
`timescale 1ns / 1ps
package emet_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 88;
   localparam int OP_W        = 2;
   localparam int REQ_W       = 96;
   localparam int RSP_W       = 16;
   localparam int OUT_W       = 7;

   localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [7:0] KIND_MAX = 8'd2;
   localparam logic [OUT_W-1:0] NO_MATCH = 7'h7F;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVAL,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic append;
      logic shift_start;
      logic shift;
      logic dec;
      logic set_ok;
      logic set_full;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic            scan_hit;
      logic            scan_end;
      logic            shift_end;
      logic [OP_W-1:0] op;
      logic            kind_ok;
      logic            is_full;
      logic            hit;
      logic            out_free;
   } status_type;

endpackage

### src/emet_ctrl.sv
// controller state machine for the exact match exclusion table
`timescale 1ns / 1ps
module emet_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  emet_pkg::status_type  status,
   output emet_pkg::cmd_type     cmd
);

   emet_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= emet_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         emet_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = emet_pkg::ST_SCAN;
            end
         end
         emet_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_hit || status.scan_end) begin
               state_in = emet_pkg::ST_EVAL;
            end
         end
         emet_pkg::ST_EVAL: begin
            state_in = emet_pkg::ST_FINISH;
            case (status.op)
               emet_pkg::OP_ADD: begin
                  if (status.kind_ok && !status.hit) begin
                     if (status.is_full) begin
                        cmd.set_full = 1'b1;
                     end else begin
                        cmd.append = 1'b1;
                        cmd.set_ok = 1'b1;
                     end
                  end
               end
               emet_pkg::OP_REMOVE: begin
                  if (status.hit) begin
                     cmd.shift_start = 1'b1;
                     state_in        = emet_pkg::ST_SHIFT;
                  end
               end
               default: begin
                  cmd.set_ok = status.hit;
               end
            endcase
         end
         emet_pkg::ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (status.shift_end) begin
               cmd.dec    = 1'b1;
               cmd.set_ok = 1'b1;
               state_in   = emet_pkg::ST_FINISH;
            end
         end
         emet_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = emet_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = emet_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### src/emet_datapath.sv
// key store, scan and shift datapath and response register
`timescale 1ns / 1ps
module emet_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [emet_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [emet_pkg::RSP_W-1:0]   rsp_tdata,
   input  emet_pkg::cmd_type            cmd,
   output emet_pkg::status_type         status
);

   logic [emet_pkg::KEY_W-1:0] mem [emet_pkg::TABLE_DEPTH];

   logic [emet_pkg::OP_W-1:0]  op_ff;
   logic [emet_pkg::KEY_W-1:0] key_ff;
   logic [emet_pkg::CNT_W-1:0] count_ff, count_in;
   logic [emet_pkg::CNT_W-1:0] iss_ff, iss_in;
   logic                       cmp_vld_ff, cmp_vld_in;
   logic [emet_pkg::IDX_W-1:0] cmp_idx_ff;
   logic [emet_pkg::KEY_W-1:0] rd_data_ff;
   logic                       hit_ff, hit_in;
   logic [emet_pkg::IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [emet_pkg::CNT_W-1:0] sh_ff, sh_in;
   logic                       pend_ff, pend_in;
   logic [emet_pkg::IDX_W-1:0] pend_addr_ff;
   logic                       ok_ff, ok_in;
   logic                       full_ff, full_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [emet_pkg::RSP_W-1:0] rsp_data_ff;

   logic                       issue;
   logic                       sh_issue;
   logic                       match;
   logic [emet_pkg::IDX_W-1:0] rd_addr;
   logic                       wr_en;
   logic [emet_pkg::IDX_W-1:0] wr_addr;
   logic [emet_pkg::KEY_W-1:0] wr_data;
   logic [emet_pkg::CNT_W-1:0] sh_prev;
   logic [31:0]                idx_wide;
   logic [31:0]                cnt_wide;
   logic [emet_pkg::OUT_W-1:0] match_index;

   assign issue    = cmd.scan && (iss_ff < count_ff);
   assign sh_issue = cmd.shift && (sh_ff < count_ff);
   assign match    = cmd.scan && cmp_vld_ff && (rd_data_ff == key_ff);
   assign rd_addr  = cmd.shift ? sh_ff[emet_pkg::IDX_W-1:0] : iss_ff[emet_pkg::IDX_W-1:0];
   assign sh_prev  = sh_ff - emet_pkg::CNT_W'(1);

   // shift writes land one place below the entry read in the previous cycle
   assign wr_en   = cmd.append || pend_ff;
   assign wr_addr = cmd.append ? count_ff[emet_pkg::IDX_W-1:0] : pend_addr_ff;
   assign wr_data = cmd.append ? key_ff : rd_data_ff;

   always_comb begin
      iss_in       = iss_ff;
      cmp_vld_in   = issue;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      sh_in        = sh_ff;
      pend_in      = sh_issue;
      count_in     = count_ff;
      ok_in        = ok_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.load) begin
         iss_in     = '0;
         cmp_vld_in = 1'b0;
         hit_in     = 1'b0;
         ok_in      = 1'b0;
         full_in    = 1'b0;
      end
      if (issue) begin
         iss_in = iss_ff + emet_pkg::CNT_W'(1);
      end
      if (match) begin
         hit_in     = 1'b1;
         hit_idx_in = cmp_idx_ff;
      end
      if (cmd.shift_start) begin
         sh_in   = emet_pkg::CNT_W'(hit_idx_ff) + emet_pkg::CNT_W'(1);
         pend_in = 1'b0;
      end else if (sh_issue) begin
         sh_in = sh_ff + emet_pkg::CNT_W'(1);
      end
      if (cmd.append) begin
         count_in = count_ff + emet_pkg::CNT_W'(1);
      end else if (cmd.dec) begin
         count_in = count_ff - emet_pkg::CNT_W'(1);
      end
      if (cmd.set_ok) begin
         ok_in = 1'b1;
      end
      if (cmd.set_full) begin
         full_in = 1'b1;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_tdata[1:0];
         key_ff <= req_tdata[89:2];
      end
      iss_ff       <= iss_in;
      cmp_idx_ff   <= iss_ff[emet_pkg::IDX_W-1:0];
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      sh_ff        <= sh_in;
      pend_addr_ff <= sh_prev[emet_pkg::IDX_W-1:0];
      ok_ff        <= ok_in;
      full_ff      <= full_in;
      if (cmd.emit) begin
         rsp_data_ff <= {cnt_wide[emet_pkg::OUT_W-1:0], full_ff, ok_ff, match_index};
      end
   end

   assign idx_wide    = 32'(hit_idx_ff);
   assign cnt_wide    = 32'(count_ff);
   assign match_index = hit_ff ? idx_wide[emet_pkg::OUT_W-1:0] : emet_pkg::NO_MATCH;

   always_comb begin
      status           = '0;
      status.scan_hit  = match;
      status.scan_end  = cmd.scan && !cmp_vld_ff && (iss_ff >= count_ff);
      status.shift_end = cmd.shift && !pend_ff && (sh_ff >= count_ff);
      status.op        = op_ff;
      status.kind_ok   = (key_ff[7:0] != 8'd0) && (key_ff[7:0] <= emet_pkg::KIND_MAX);
      status.is_full   = count_ff >= emet_pkg::CNT_W'(emet_pkg::TABLE_DEPTH);
      status.hit       = hit_ff;
      status.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### src/exact_match_exclusion_table.sv
// exact match exclusion table: linear scan over an ordered key store per request
// a request is scanned entry by entry through the one-read-port key memory, then evaluated;
// a remove then shifts the later entries down, and the response waits for a free output
// throughput: one request at a time, a new one is taken once the last response is registered
// reset clears the entry count and control state; key memory contents are kept as they are
`timescale 1ns / 1ps
module exact_match_exclusion_table (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // op, exc_kind, item_kind, item_subkind, material_kind, material_number, zero pad
   input  logic [emet_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // match_index, success, table_full, entry_count
   output logic [emet_pkg::RSP_W-1:0] rsp_tdata
);

   emet_pkg::cmd_type    cmd;
   emet_pkg::status_type status;

   emet_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   emet_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

### test/tb.sv
// self-checking stream testbench for the exact match exclusion table
`timescale 1ns / 1ps
module tb;

   localparam logic [emet_pkg::OP_W-1:0] OP_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 1250;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLD_CYCLES  = 500;
   localparam int DRAIN_CYCLES = 300;
   localparam int PRINT_LIMIT  = 60;

   typedef struct {
      logic [emet_pkg::OP_W-1:0] op;
      logic [7:0]                kind;
      logic [15:0]               item;
      logic [15:0]               subitem;
      logic [15:0]               material;
      logic [31:0]               matnum;
   } excl_req_type;

   typedef struct {
      logic [emet_pkg::OUT_W-1:0] match_index;
      logic                       success;
      logic                       table_full;
      logic [emet_pkg::OUT_W-1:0] entry_count;
   } excl_rsp_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [emet_pkg::REQ_W-1:0] req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [emet_pkg::RSP_W-1:0] rsp_tdata;

   excl_req_type pending_requests[$];
   excl_rsp_type expected_responses[$];
   excl_req_type on_bus;
   excl_rsp_type want;

   // shadow copy of the key store, updated as each request is taken
   logic [7:0]  tbl_kind     [emet_pkg::TABLE_DEPTH];
   logic [15:0] tbl_item     [emet_pkg::TABLE_DEPTH];
   logic [15:0] tbl_subitem  [emet_pkg::TABLE_DEPTH];
   logic [15:0] tbl_material [emet_pkg::TABLE_DEPTH];
   logic [31:0] tbl_matnum   [emet_pkg::TABLE_DEPTH];
   int          tbl_count = 0;

   int err_count     = 0;
   int cycles        = 0;
   int send_idle_pct = 38;
   int recv_idle_pct = 62;
   int holds_asked   = 0;
   int holds_done    = 0;
   int hold_left     = 0;

   exact_match_exclusion_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic excl_rsp_type apply_to_table(excl_req_type r);
      excl_rsp_type e;
      int           hit;
      hit = -1;
      for (int i = 0; i < tbl_count; i++) begin
         if (hit < 0 && tbl_kind[i] == r.kind && tbl_item[i] == r.item &&
             tbl_subitem[i] == r.subitem && tbl_material[i] == r.material &&
             tbl_matnum[i] == r.matnum) begin
            hit = i;
         end
      end
      e.success    = 1'b0;
      e.table_full = 1'b0;
      case (r.op)
         emet_pkg::OP_ADD: begin
            // kind is checked before the duplicate, room last
            if (r.kind != 8'd0 && r.kind <= emet_pkg::KIND_MAX && hit < 0) begin
               if (tbl_count >= emet_pkg::TABLE_DEPTH) begin
                  e.table_full = 1'b1;
               end else begin
                  tbl_kind[tbl_count]     = r.kind;
                  tbl_item[tbl_count]     = r.item;
                  tbl_subitem[tbl_count]  = r.subitem;
                  tbl_material[tbl_count] = r.material;
                  tbl_matnum[tbl_count]   = r.matnum;
                  tbl_count++;
                  e.success = 1'b1;
               end
            end
         end
         emet_pkg::OP_REMOVE: begin
            if (hit >= 0) begin
               for (int i = hit; i < tbl_count - 1; i++) begin
                  tbl_kind[i]     = tbl_kind[i + 1];
                  tbl_item[i]     = tbl_item[i + 1];
                  tbl_subitem[i]  = tbl_subitem[i + 1];
                  tbl_material[i] = tbl_material[i + 1];
                  tbl_matnum[i]   = tbl_matnum[i + 1];
               end
               tbl_count--;
               e.success = 1'b1;
            end
         end
         default: begin
            // the spare code behaves as a find
            e.success = (hit >= 0);
         end
      endcase
      e.match_index = (hit < 0) ? emet_pkg::NO_MATCH : emet_pkg::OUT_W'(hit);
      e.entry_count = emet_pkg::OUT_W'(tbl_count);
      return e;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
      err_count++;
      if (err_count <= PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s got %0h wanted %0h", cycles, what, got, exp_val);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            expected_responses.insert(expected_responses.size(), apply_to_table(on_bus));
         if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            on_bus = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {{(emet_pkg::REQ_W - 90){1'b0}}, on_bus.matnum, on_bus.material,
                           on_bus.subitem, on_bus.item, on_bus.kind, on_bus.op};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_responses.size() == 0) begin
               report_mismatch("response with nothing pending", 32'(rsp_tdata), 32'd0);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_tdata[6:0] !== want.match_index)
                  report_mismatch("match_index", 32'(rsp_tdata[6:0]),
                                  32'(want.match_index));
               if (rsp_tdata[7] !== want.success)
                  report_mismatch("success", 32'(rsp_tdata[7]), 32'(want.success));
               if (rsp_tdata[8] !== want.table_full)
                  report_mismatch("table_full", 32'(rsp_tdata[8]), 32'(want.table_full));
               if (rsp_tdata[15:9] !== want.entry_count)
                  report_mismatch("entry_count", 32'(rsp_tdata[15:9]),
                                  32'(want.entry_count));
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // long receiver hold-offs, one for each that the stimulus asks for
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         holds_done <= 0;
      end else if (hold_left == 0 && holds_done != holds_asked) begin
         hold_left  <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic offer(excl_req_type r);
      while (pending_requests.size() != 0)
         @(negedge clock);
      pending_requests.insert(pending_requests.size(), r);
   endtask

   task automatic send(logic [emet_pkg::OP_W-1:0] op, logic [7:0] kind, logic [15:0] item,
                       logic [15:0] subitem, logic [15:0] material, logic [31:0] matnum);
      excl_req_type r;
      r.op       = op;
      r.kind     = kind;
      r.item     = item;
      r.subitem  = subitem;
      r.material = material;
      r.matnum   = matnum;
      offer(r);
   endtask

   task automatic wait_quiet();
      while (pending_requests.size() != 0 || req_tvalid || expected_responses.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [emet_pkg::OP_W-1:0] pick_op(int add_pct, int remove_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < add_pct)
         return emet_pkg::OP_ADD;
      if (roll < add_pct + remove_pct)
         return emet_pkg::OP_REMOVE;
      if (roll >= 95)
         return OP_SPARE;
      return emet_pkg::OP_FIND;
   endfunction

   // random key, a stored key, or a stored key with one bit flipped
   function automatic excl_req_type make_request(logic [emet_pkg::OP_W-1:0] op, int hit_pct);
      excl_req_type r;
      int           roll;
      int           idx;
      r.op       = op;
      r.kind     = 8'($urandom);
      r.item     = 16'($urandom);
      r.subitem  = 16'($urandom);
      r.material = 16'($urandom);
      r.matnum   = 32'($urandom);
      roll       = $urandom_range(0, 99);
      if (tbl_count > 0 && roll < hit_pct + 15) begin
         idx        = $urandom_range(0, tbl_count - 1);
         r.kind     = tbl_kind[idx];
         r.item     = tbl_item[idx];
         r.subitem  = tbl_subitem[idx];
         r.material = tbl_material[idx];
         r.matnum   = tbl_matnum[idx];
         if (roll >= hit_pct) begin
            case ($urandom_range(0, 4))
               0: r.kind[$urandom_range(0, 7)]      = ~r.kind[0];
               1: r.item[$urandom_range(0, 15)]     ^= 1'b1;
               2: r.subitem[$urandom_range(0, 15)]  ^= 1'b1;
               3: r.material[$urandom_range(0, 15)] ^= 1'b1;
               default: r.matnum[$urandom_range(0, 31)] ^= 1'b1;
            endcase
            if (r.kind == tbl_kind[idx])
               r.kind ^= 8'h01;
         end
      end else if (op == emet_pkg::OP_ADD) begin
         if ($urandom_range(0, 99) < 15)
            r.kind = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(3, 255));
         else
            r.kind = 8'($urandom_range(1, 2));
      end
      return r;
   endfunction

   initial begin
      excl_req_type r;
      int           sent;
      int           seg;
      int           n;
      int           extra;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table, refused kinds
      send(emet_pkg::OP_FIND,   8'd1,   16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
      send(emet_pkg::OP_REMOVE, 8'd1,   16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
      send(emet_pkg::OP_ADD,    8'd0,   16'h1234, 16'h5678, 16'h9abc, 32'hdead_beef);
      send(emet_pkg::OP_ADD,    8'd3,   16'h1234, 16'h5678, 16'h9abc, 32'hdead_beef);
      send(emet_pkg::OP_ADD,    8'd255, 16'h1234, 16'h5678, 16'h9abc, 32'hdead_beef);
      // field extremes
      send(emet_pkg::OP_ADD,    8'd1,   16'h7fff, 16'h8000, 16'h8000, 32'h8000_0000);
      send(emet_pkg::OP_ADD,    8'd2,   16'hffff, 16'hffff, 16'h7fff, 32'h7fff_ffff);
      send(emet_pkg::OP_ADD,    8'd1,   16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
      // duplicate, then same key under the other kind
      send(emet_pkg::OP_ADD,    8'd1,   16'h7fff, 16'h8000, 16'h8000, 32'h8000_0000);
      send(emet_pkg::OP_ADD,    8'd2,   16'h7fff, 16'h8000, 16'h8000, 32'h8000_0000);
      send(emet_pkg::OP_FIND,   8'd2,   16'hffff, 16'hffff, 16'h7fff, 32'h7fff_ffff);
      send(OP_SPARE,            8'd1,   16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
      send(emet_pkg::OP_FIND,   8'd1,   16'h7fff, 16'h8000, 16'h8000, 32'h8000_0000);
      send(emet_pkg::OP_FIND,   8'd1,   16'hffff, 16'hffff, 16'h7fff, 32'h7fff_ffff);
      // remove from the middle, miss, then first and last
      send(emet_pkg::OP_REMOVE, 8'd2,   16'hffff, 16'hffff, 16'h7fff, 32'h7fff_ffff);
      send(emet_pkg::OP_FIND,   8'd1,   16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
      send(emet_pkg::OP_REMOVE, 8'd2,   16'hffff, 16'hffff, 16'h7fff, 32'h7fff_ffff);
      send(emet_pkg::OP_REMOVE, 8'd1,   16'h7fff, 16'h8000, 16'h8000, 32'h8000_0000);
      send(emet_pkg::OP_FIND,   8'd2,   16'h7fff, 16'h8000, 16'h8000, 32'h8000_0000);
      send(emet_pkg::OP_REMOVE, 8'd2,   16'h7fff, 16'h8000, 16'h8000, 32'h8000_0000);
      send(emet_pkg::OP_ADD,    8'd2,   16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff);
      send(OP_SPARE,            8'd255, 16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff);
      wait_quiet();

      // segments cycle through filling, mixed traffic, draining, mixed traffic
      sent  = 0;
      seg   = 0;
      n     = 0;
      extra = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent == RANDOM_ITEMS / 3) begin
            wait_quiet();
            send_idle_pct = 62;
            recv_idle_pct = 38;
         end
         if (sent == 2 * RANDOM_ITEMS / 3) begin
            wait_quiet();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (sent == 100 || sent == 2 * RANDOM_ITEMS / 3 + 100)
            holds_asked++;
         case (seg)
            0:       r = make_request(pick_op(85, 5), 10);
            2:       r = make_request(pick_op(10, 80), 80);
            default: r = make_request(pick_op(35, 30), 45);
         endcase
         offer(r);
         sent++;
         n++;
         if ((seg == 0 && tbl_count == emet_pkg::TABLE_DEPTH) || (seg == 2 && tbl_count == 0))
            extra++;
         if (extra >= 12 || n >= 160 || (seg[0] && n >= 60)) begin
            seg   = (seg + 1) % 4;
            n     = 0;
            extra = 0;
         end
      end

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
